// ===== rtl/fat16rs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat16rs_pkg
// Shared types and constants for the FAT16 file read sequencer.
// ----------------------------------------------------------------------------
package fat16rs_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int COPY_W       = SECTOR_SHIFT + 1;
  localparam logic [15:0] EOC_MIN = 16'hFFF8;
  localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_FAT  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    OP_START     = 2'd0,
    OP_DATA_DONE = 2'd1,
    OP_FAT_WORD  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_FAT  = 2'd1,
    KIND_OK   = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_FAT_START   = 3'd0,
    REG_DATA_START  = 3'd1,
    REG_SPC         = 3'd2,
    REG_START_CLUS  = 3'd3,
    REG_FILE_LEN    = 3'd4,
    REG_BUF_CAP     = 3'd5,
    REG_IS_DIR      = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] fat_base_lba;
    logic [31:0] data_base_lba;
    logic [7:0]  clus_sectors;
    logic [15:0] start_cluster;
    logic [31:0] file_length;
    logic [31:0] buffer_capacity;
    logic        entry_is_directory;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [31:0]             sector_lba;
    logic [COPY_W-1:0]       copy_bytes;
    logic [31:0]             buffer_offset;
    logic [SECTOR_SHIFT-1:0] fat_word_offset;
    logic [31:0]             total_bytes;
  } res_t;

endpackage

// ===== rtl/fat16rs_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat16rs_engine
// Walk state and combinational next-step logic for one event.
// ----------------------------------------------------------------------------
module fat16rs_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [1:0]          op,
  input  logic                failed,
  input  logic [15:0]         fat_value,
  input  fat16rs_pkg::cfg_t   cfg,
  output logic                res_valid,
  output fat16rs_pkg::res_t   res
);

  fat16rs_pkg::phase_t phase, phase_next;
  logic [15:0] current_cluster, current_cluster_next;
  logic [7:0]  sector_in_cluster, sector_in_cluster_next;
  logic [31:0] bytes_delivered, bytes_delivered_next;
  logic [31:0] read_length, read_length_next;
  logic [fat16rs_pkg::COPY_W-1:0] pending_copy, pending_copy_next;
  logic [31:0] cluster_base_lba, cluster_base_lba_next;

  // walk path (start or FAT word)
  logic [15:0] w_cluster;
  logic [31:0] w_bytes, w_len, w_diff, w_base, len_min;
  logic [39:0] w_prod;
  logic        w_done;
  // data-done path
  logic [31:0] d_bytes;
  logic [7:0]  d_sec;
  logic        d_more;
  // data request
  logic [31:0] is_base, is_bytes, is_len, is_rem;
  logic [7:0]  is_sec;
  logic [fat16rs_pkg::COPY_W-1:0] is_copy;
  // FAT request
  logic [15:0] f_cluster;
  logic [16:0] f_off;
  logic [31:0] f_lba;
  logic        is_data_op;
  logic        do_walk, do_data, do_fat, do_err, do_ok;

  assign is_data_op = (op == fat16rs_pkg::OP_DATA_DONE);

  assign len_min   = (cfg.file_length > cfg.buffer_capacity) ?
                     cfg.buffer_capacity : cfg.file_length;
  assign w_cluster = (op == fat16rs_pkg::OP_START) ? cfg.start_cluster : fat_value;
  assign w_bytes   = (op == fat16rs_pkg::OP_START) ? 32'd0 : bytes_delivered;
  assign w_len     = (op == fat16rs_pkg::OP_START) ? len_min : read_length;
  assign w_diff    = {16'd0, w_cluster} - fat16rs_pkg::FIRST_DATA_CLUSTER;
  assign w_prod    = {8'd0, w_diff} * {32'd0, cfg.clus_sectors};
  assign w_base    = cfg.data_base_lba + w_prod[31:0];
  assign w_done    = (w_cluster == 16'd0) || (w_cluster >= fat16rs_pkg::EOC_MIN) ||
                     (w_bytes >= w_len);

  assign d_bytes = bytes_delivered + {{(32-fat16rs_pkg::COPY_W){1'b0}}, pending_copy};
  assign d_sec   = sector_in_cluster + 8'd1;
  assign d_more  = (d_sec < cfg.clus_sectors) && (d_bytes < read_length);

  assign is_base  = is_data_op ? cluster_base_lba : w_base;
  assign is_sec   = is_data_op ? d_sec : 8'd0;
  assign is_bytes = is_data_op ? d_bytes : w_bytes;
  assign is_len   = is_data_op ? read_length : w_len;
  assign is_rem   = is_len - is_bytes;
  assign is_copy  = (is_rem < 32'(fat16rs_pkg::SECTOR_BYTES)) ?
                    is_rem[fat16rs_pkg::COPY_W-1:0] :
                    fat16rs_pkg::COPY_W'(fat16rs_pkg::SECTOR_BYTES);

  // byte offset of the next-cluster word: cluster * 2
  assign f_cluster = is_data_op ? current_cluster : w_cluster;
  assign f_off     = {f_cluster, 1'b0};
  assign f_lba     = cfg.fat_base_lba + 32'(f_off >> fat16rs_pkg::SECTOR_SHIFT);

  always_comb begin
    phase_next             = phase;
    current_cluster_next   = current_cluster;
    sector_in_cluster_next = sector_in_cluster;
    bytes_delivered_next   = bytes_delivered;
    read_length_next       = read_length;
    pending_copy_next      = pending_copy;
    cluster_base_lba_next  = cluster_base_lba;
    do_walk = 1'b0;
    do_data = 1'b0;
    do_fat  = 1'b0;
    do_err  = 1'b0;
    do_ok   = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    unique case (op)
      fat16rs_pkg::OP_START: begin
        if (go && phase == fat16rs_pkg::PH_IDLE) begin
          if (cfg.entry_is_directory) begin
            do_err = 1'b1;
          end else begin
            read_length_next     = len_min;
            bytes_delivered_next = 32'd0;
            current_cluster_next = cfg.start_cluster;
            do_walk = 1'b1;
          end
        end
      end
      fat16rs_pkg::OP_DATA_DONE: begin
        if (go && phase == fat16rs_pkg::PH_DATA) begin
          if (failed) begin
            do_err = 1'b1;
          end else begin
            bytes_delivered_next   = d_bytes;
            pending_copy_next      = '0;
            sector_in_cluster_next = d_sec;
            if (d_more) do_data = 1'b1;
            else        do_fat  = 1'b1;
          end
        end
      end
      fat16rs_pkg::OP_FAT_WORD: begin
        if (go && phase == fat16rs_pkg::PH_FAT) begin
          if (failed) begin
            do_err = 1'b1;
          end else begin
            current_cluster_next = fat_value;
            do_walk = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (do_walk) begin
      if (w_done) begin
        do_ok = 1'b1;
      end else begin
        cluster_base_lba_next  = w_base;
        sector_in_cluster_next = 8'd0;
        if (cfg.clus_sectors == 8'd0) do_fat  = 1'b1;
        else                          do_data = 1'b1;
      end
    end

    if (do_err) begin
      res_valid  = 1'b1;
      res.kind   = fat16rs_pkg::KIND_ERR;
      phase_next = fat16rs_pkg::PH_IDLE;
    end else if (do_ok) begin
      res_valid       = 1'b1;
      res.kind        = fat16rs_pkg::KIND_OK;
      res.total_bytes = w_bytes;
      phase_next      = fat16rs_pkg::PH_IDLE;
    end else if (do_data) begin
      res_valid         = 1'b1;
      res.kind          = fat16rs_pkg::KIND_DATA;
      res.sector_lba    = is_base + {24'd0, is_sec};
      res.copy_bytes    = is_copy;
      res.buffer_offset = is_bytes;
      pending_copy_next = is_copy;
      phase_next        = fat16rs_pkg::PH_DATA;
    end else if (do_fat) begin
      res_valid           = 1'b1;
      res.kind            = fat16rs_pkg::KIND_FAT;
      res.sector_lba      = f_lba;
      res.fat_word_offset = f_off[fat16rs_pkg::SECTOR_SHIFT-1:0];
      phase_next          = fat16rs_pkg::PH_FAT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fat16rs_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // walk payload; only read after a start has loaded it
  always_ff @(posedge clk) begin
    current_cluster   <= current_cluster_next;
    sector_in_cluster <= sector_in_cluster_next;
    bytes_delivered   <= bytes_delivered_next;
    read_length       <= read_length_next;
    pending_copy      <= pending_copy_next;
    cluster_base_lba  <= cluster_base_lba_next;
  end

endmodule

// ===== rtl/fat16rs_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat16rs_out_reg
// Result register; holds a transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module fat16rs_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  fat16rs_pkg::res_t in_res,
  output logic              load_ok,
  output logic              out_valid,
  input  logic              out_stall,
  output fat16rs_pkg::res_t out_res
);

  assign load_ok = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && in_valid) begin
      out_res <= in_res;
    end
  end

endmodule

// ===== rtl/fat16_file_read_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat16_file_read_sequencer_core
// Walks the FAT16 cluster chain of one file and issues sector requests.
// ----------------------------------------------------------------------------
// Usage:
//  - Program the seven setup registers over the cfg port (index = register
//    number, cfg_ready is always high) while no event is in flight.
//  - Events enter on event_valid/event_stall: operation 0 starts a read,
//    1 reports a finished data sector read, 2 returns the next-cluster FAT
//    word. read_failed flags a failed sector read behind the event.
//  - Each event gives at most one result transaction on result_valid/
//    result_stall: read a data sector, read a FAT sector, finished ok or
//    finished with error. Events that do not fit the current phase are
//    consumed silently.
//  - Path: an accepted event passes the input register, then the step
//    logic with its 32x8 cluster-to-LBA multiply feeding the result
//    register, which drives result_valid.
//  - Throughput: one event per cycle while the receiver keeps up.
//  - Receiver stall: the result register holds its transaction; the input
//    register takes one more event if it is empty, then event_stall rises.
//  - Reset: synchronous, active high. Walk goes idle, pipeline empties and
//    the setup registers return to their defaults (one sector per cluster,
//    everything else zero).
// ----------------------------------------------------------------------------
module fat16_file_read_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  // event channel
  input  logic        event_valid,
  output logic        event_stall,
  input  logic [1:0]  operation,
  input  logic        read_failed,
  input  logic [15:0] fat_value,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [31:0] sector_lba,
  output logic [fat16rs_pkg::COPY_W-1:0]       copy_bytes,
  output logic [31:0] buffer_offset,
  output logic [fat16rs_pkg::SECTOR_SHIFT-1:0] fat_word_offset,
  output logic [31:0] total_bytes,
  // setup register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  fat16rs_pkg::cfg_t cfg;
  fat16rs_pkg::res_t eng_res, out_res;
  logic              eng_valid;
  logic              load_ok;

  // input register
  logic        ev_valid;
  logic [1:0]  ev_op;
  logic        ev_failed;
  logic [15:0] ev_fat;
  logic        ev_take;

  assign cfg_ready = 1'b1;

  // setup registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fat_base_lba        <= 32'd0;
      cfg.data_base_lba       <= 32'd0;
      cfg.clus_sectors        <= 8'd1;
      cfg.start_cluster       <= 16'd0;
      cfg.file_length         <= 32'd0;
      cfg.buffer_capacity     <= 32'd0;
      cfg.entry_is_directory  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fat16rs_pkg::REG_FAT_START:  cfg.fat_base_lba        <= cfg_data;
        fat16rs_pkg::REG_DATA_START: cfg.data_base_lba       <= cfg_data;
        fat16rs_pkg::REG_SPC:        cfg.clus_sectors        <= cfg_data[7:0];
        fat16rs_pkg::REG_START_CLUS: cfg.start_cluster       <= cfg_data[15:0];
        fat16rs_pkg::REG_FILE_LEN:   cfg.file_length         <= cfg_data;
        fat16rs_pkg::REG_BUF_CAP:    cfg.buffer_capacity     <= cfg_data;
        fat16rs_pkg::REG_IS_DIR:     cfg.entry_is_directory  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the held event moves into the step logic whenever the result register
  // can take what it produces
  assign ev_take     = ev_valid && load_ok;
  assign event_stall = ev_valid && !load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (!event_stall) begin
      ev_valid <= event_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (event_valid && !event_stall) begin
      ev_op     <= operation;
      ev_failed <= read_failed;
      ev_fat    <= fat_value;
    end
  end

  fat16rs_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .go        (ev_take),
    .op        (ev_op),
    .failed    (ev_failed),
    .fat_value (ev_fat),
    .cfg       (cfg),
    .res_valid (eng_valid),
    .res       (eng_res)
  );

  fat16rs_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (eng_valid),
    .in_res    (eng_res),
    .load_ok   (load_ok),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_res   (out_res)
  );

  assign kind            = out_res.kind;
  assign sector_lba      = out_res.sector_lba;
  assign copy_bytes      = out_res.copy_bytes;
  assign buffer_offset   = out_res.buffer_offset;
  assign fat_word_offset = out_res.fat_word_offset;
  assign total_bytes     = out_res.total_bytes;

endmodule

// ===== sim/fat16rs_chain_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat16rs_chain_checker
// Watches the event, result and setup channels of the FAT16 read sequencer,
// predicts each sector request from its own model of the cluster walk and
// compares the result transactions against it in order.
// ----------------------------------------------------------------------------
module fat16rs_chain_checker
  import fat16rs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    event_valid,
  input  logic                    event_stall,
  input  logic [1:0]              operation,
  input  logic                    read_failed,
  input  logic [15:0]             fat_value,
  input  logic                    result_valid,
  input  logic                    result_stall,
  input  logic [1:0]              kind,
  input  logic [31:0]             sector_lba,
  input  logic [COPY_W-1:0]       copy_bytes,
  input  logic [31:0]             buffer_offset,
  input  logic [SECTOR_SHIFT-1:0] fat_word_offset,
  input  logic [31:0]             total_bytes,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  output int                      errors,
  output int                      outstanding
);

  cfg_t              setup;
  phase_t            walk_phase;
  logic [15:0]       cluster;
  logic [7:0]        sector_idx;
  logic [31:0]       delivered;
  logic [31:0]       length_cap;
  logic [31:0]       base_lba;
  logic [COPY_W-1:0] copy_due;

  res_t requests_due[$];
  int   mismatches = 0;
  int   pending_n  = 0;

  assign errors      = mismatches;
  assign outstanding = pending_n;

  task automatic request_data(output res_t r);
    logic [31:0] left;
    left = length_cap - delivered;
    copy_due = (left < 32'(SECTOR_BYTES)) ? COPY_W'(left) : COPY_W'(SECTOR_BYTES);
    walk_phase = PH_DATA;
    r = '0;
    r.kind          = KIND_DATA;
    r.sector_lba    = base_lba + {24'd0, sector_idx};
    r.copy_bytes    = copy_due;
    r.buffer_offset = delivered;
  endtask

  task automatic request_fat(output res_t r);
    logic [16:0] byte_off;
    byte_off = {cluster, 1'b0};
    walk_phase = PH_FAT;
    r = '0;
    r.kind            = KIND_FAT;
    r.sector_lba      = setup.fat_base_lba + 32'(byte_off >> SECTOR_SHIFT);
    r.fat_word_offset = byte_off[SECTOR_SHIFT-1:0];
  endtask

  // Enter the cluster held in 'cluster', or finish the walk.
  task automatic enter_cluster(output res_t r);
    if (cluster == 16'd0 || cluster >= EOC_MIN || delivered >= length_cap) begin
      walk_phase = PH_IDLE;
      r = '0;
      r.kind        = KIND_OK;
      r.total_bytes = delivered;
    end else begin
      base_lba = setup.data_base_lba +
                 (32'(cluster) - FIRST_DATA_CLUSTER) * 32'(setup.clus_sectors);
      sector_idx = '0;
      if (setup.clus_sectors == 8'd0) request_fat(r);
      else request_data(r);
    end
  endtask

  task automatic abort_walk(output res_t r);
    walk_phase = PH_IDLE;
    r = '0;
    r.kind = KIND_ERR;
  endtask

  task automatic walk_predict(input logic [1:0] op, input logic failed,
                              input logic [15:0] link, output bit produced,
                              output res_t r);
    produced = 1'b1;
    r = '0;
    if (op == OP_START && walk_phase == PH_IDLE) begin
      if (setup.entry_is_directory) begin
        abort_walk(r);
      end else begin
        length_cap = (setup.file_length > setup.buffer_capacity) ?
                     setup.buffer_capacity : setup.file_length;
        delivered = '0;
        cluster = setup.start_cluster;
        enter_cluster(r);
      end
    end else if (op == OP_DATA_DONE && walk_phase == PH_DATA) begin
      if (failed) begin
        abort_walk(r);
      end else begin
        delivered = delivered + 32'(copy_due);
        copy_due = '0;
        sector_idx = sector_idx + 8'd1;
        if (sector_idx < setup.clus_sectors && delivered < length_cap)
          request_data(r);
        else
          request_fat(r);
      end
    end else if (op == OP_FAT_WORD && walk_phase == PH_FAT) begin
      if (failed) begin
        abort_walk(r);
      end else begin
        cluster = link;
        enter_cluster(r);
      end
    end else begin
      produced = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    res_t fresh;
    bit   produced;
    if (rst) begin
      setup = '0;
      setup.clus_sectors = 8'd1;
      walk_phase = PH_IDLE;
      cluster    = '0;
      sector_idx = '0;
      delivered  = '0;
      length_cap = '0;
      copy_due   = '0;
      base_lba   = '0;
      requests_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FAT_START:  setup.fat_base_lba        = cfg_data;
          REG_DATA_START: setup.data_base_lba       = cfg_data;
          REG_SPC:        setup.clus_sectors        = cfg_data[7:0];
          REG_START_CLUS: setup.start_cluster       = cfg_data[15:0];
          REG_FILE_LEN:   setup.file_length         = cfg_data;
          REG_BUF_CAP:    setup.buffer_capacity     = cfg_data;
          REG_IS_DIR:     setup.entry_is_directory  = cfg_data[0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        got = {kind, sector_lba, copy_bytes, buffer_offset, fat_word_offset, total_bytes};
        if (requests_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result transaction with none expected, kind %0d lba %h",
                     kind, sector_lba);
        end else begin
          want = requests_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: expected kind %0d lba %h copy %0d off %h word %0d total %0d",
                       want.kind, want.sector_lba, want.copy_bytes, want.buffer_offset,
                       want.fat_word_offset, want.total_bytes);
              $display("       actual   kind %0d lba %h copy %0d off %h word %0d total %0d",
                       got.kind, got.sector_lba, got.copy_bytes, got.buffer_offset,
                       got.fat_word_offset, got.total_bytes);
            end
          end
        end
      end
      if (event_valid && !event_stall) begin
        walk_predict(operation, read_failed, fat_value, produced, fresh);
        if (produced) requests_due.push_back(fresh);
      end
    end
    pending_n <= requests_due.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the FAT16 read sequencer through directed corner walks and then
// randomized files: random setup, well-formed event chains with random
// cluster links and read failures, and misplaced events mixed in. A checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import fat16rs_pkg::*;

  localparam int          ITEMS      = 1300;    // events to send, misplaced ones included
  localparam int          LIMIT      = 400000;  // cycle budget for the run
  localparam int          DRAIN      = 6;       // cycles to flush the 2-stage pipe
  localparam logic [1:0]  OP_UNUSED  = 2'd3;    // never a valid operation
  localparam logic [2:0]  REG_UNUSED = 3'd7;    // no register behind this index

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        event_valid  = 1'b0;
  logic        event_stall;
  logic [1:0]  operation    = '0;
  logic        read_failed  = 1'b0;
  logic [15:0] fat_value    = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  kind;
  logic [31:0] sector_lba;
  logic [COPY_W-1:0]       copy_bytes;
  logic [31:0]             buffer_offset;
  logic [SECTOR_SHIFT-1:0] fat_word_offset;
  logic [31:0] total_bytes;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index    = '0;
  logic [31:0] cfg_data     = '0;

  int     errors;
  int     outstanding;
  int     cycles = 0;
  int     items  = 0;
  bit     calm   = 1'b0;    // set: neither side idles
  phase_t walk_at = PH_IDLE; // walk phase as seen from the last result

  fat16_file_read_sequencer_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .event_valid     (event_valid),
    .event_stall     (event_stall),
    .operation       (operation),
    .read_failed     (read_failed),
    .fat_value       (fat_value),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .kind            (kind),
    .sector_lba      (sector_lba),
    .copy_bytes      (copy_bytes),
    .buffer_offset   (buffer_offset),
    .fat_word_offset (fat_word_offset),
    .total_bytes     (total_bytes),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  fat16rs_chain_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .event_valid     (event_valid),
    .event_stall     (event_stall),
    .operation       (operation),
    .read_failed     (read_failed),
    .fat_value       (fat_value),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .kind            (kind),
    .sector_lba      (sector_lba),
    .copy_bytes      (copy_bytes),
    .buffer_offset   (buffer_offset),
    .fat_word_offset (fat_word_offset),
    .total_bytes     (total_bytes),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .errors          (errors),
    .outstanding     (outstanding)
  );

  always #5 clk = ~clk;

  // Watchdog: a lost result or a stuck handshake ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("fat16_file_read_sequencer_core: mismatch");
      $finish;
    end
  end

  // Receiver side: random stall about a third of the time, none while calm.
  always @(posedge clk) begin
    if (rst) result_stall <= 1'b0;
    else result_stall <= !calm && ($urandom_range(0, 99) < 34);
  end

  // Follow the walk from the results so the stimulus knows which event fits next.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      case (kind)
        KIND_DATA: walk_at <= PH_DATA;
        KIND_FAT:  walk_at <= PH_FAT;
        default:   walk_at <= PH_IDLE;
      endcase
    end
  end

  function automatic logic [1:0] fitting_op(phase_t ph);
    case (ph)
      PH_DATA: return OP_DATA_DONE;
      PH_FAT:  return OP_FAT_WORD;
      default: return OP_START;
    endcase
  endfunction

  // Random next-cluster word: chain ends, cluster one, small and wide clusters.
  function automatic logic [15:0] chain_link();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'd0;
    if (r < 16) return 16'($urandom_range(32'hFFF8, 32'hFFFF));
    if (r < 19) return 16'd1;
    if (r < 55) return 16'($urandom_range(2, 300));
    return 16'($urandom);
  endfunction

  // One event transaction; the sender may idle before it.
  task automatic send(input logic [1:0] op, input logic failed, input logic [15:0] link);
    items++;
    while (!calm && $urandom_range(0, 99) < 34) begin
      event_valid <= 1'b0;
      @(posedge clk);
    end
    event_valid <= 1'b1;
    operation   <= op;
    read_failed <= failed;
    fat_value   <= link;
    @(posedge clk);
    while (event_stall) @(posedge clk);
  endtask

  // Hold off the sender until every predicted result has arrived.
  task automatic settle();
    event_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // One walk step. Noisy steps wrap the event in misplaced events: wrong ones
  // for the current phase before it, never-valid ones right behind it, the first
  // of which waits in the input register while the result waits.
  task automatic act(input logic [1:0] op, input logic failed, input logic [15:0] link,
                     input bit noisy);
    calm = (items >= 600 && items < 800);
    if (noisy && $urandom_range(0, 99) < 20)
      repeat ($urandom_range(1, 2))
        send(fitting_op(walk_at) + 2'($urandom_range(1, 3)), 1'($urandom), 16'($urandom));
    send(op, failed, link);
    if (noisy && $urandom_range(0, 99) < 20)
      repeat ($urandom_range(1, 3)) send(OP_UNUSED, 1'($urandom), 16'($urandom));
    settle();
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Setup only changes with the block idle: results all in, pipe flushed.
  task automatic quiesce();
    settle();
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic random_setup();
    int r;
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 99);
      put_reg(REG_FAT_START, (r < 10) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom);
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 99);
      put_reg(REG_DATA_START, (r < 10) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom);
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 99);
      // upper bits are junk on purpose; only the low byte counts
      put_reg(REG_SPC, {24'($urandom_range(0, 32'hFF_FFFF)),
                        (r < 4) ? 8'd0 : (r < 6) ? 8'd255 :
                        (r < 75) ? 8'($urandom_range(1, 4)) : 8'($urandom_range(1, 16))});
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 99);
      put_reg(REG_START_CLUS, {16'($urandom),
                               (r < 5) ? 16'd0 : (r < 10) ? 16'd1 :
                               (r < 15) ? 16'($urandom_range(32'hFFF8, 32'hFFFF)) :
                               (r < 70) ? 16'($urandom_range(2, 400)) :
                               16'($urandom_range(2, 32'hFFF7))});
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 99);
      put_reg(REG_FILE_LEN, (r < 8) ? 32'd0 : (r < 70) ? $urandom_range(1, 4096) :
                            (r < 85) ? $urandom_range(1, 20000) : $urandom);
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 99);
      put_reg(REG_BUF_CAP, (r < 5) ? 32'd0 : (r < 45) ? $urandom_range(1, 4096) :
                           (r < 60) ? 32'hFFFF_FFFF : $urandom_range(1, 20000));
    end
    // directory flag written every time, mostly clear
    put_reg(REG_IS_DIR, {31'($urandom), 1'($urandom_range(0, 99) < 6)});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part ---
    // defaults after reset: start cluster zero finishes at once
    act(OP_START, 1'b0, 16'h0000, 1'b0);
    // directory entry fails on start; misplaced events while idle do nothing
    put_reg(REG_IS_DIR, 32'h0000_0001);
    cfg_valid <= 1'b0;
    act(OP_START, 1'b1, 16'hFFFF, 1'b0);
    act(OP_DATA_DONE, 1'b1, 16'hFFFF, 1'b0);
    act(OP_FAT_WORD, 1'b0, 16'h0002, 1'b0);
    act(OP_UNUSED, 1'b1, 16'hFFFF, 1'b0);

    // cluster one with a wrapping data base, largest cluster size, partial sector
    quiesce();
    put_reg(REG_IS_DIR, 32'hFFFF_FFFE);
    put_reg(REG_FAT_START, 32'hFFFF_FFF0);
    put_reg(REG_DATA_START, 32'hFFFF_FFFF);
    put_reg(REG_SPC, 32'h0000_00FF);
    put_reg(REG_START_CLUS, 32'h0000_0001);
    put_reg(REG_FILE_LEN, 32'd700);
    put_reg(REG_BUF_CAP, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    act(OP_START, 1'b0, 16'h0000, 1'b0);
    act(OP_DATA_DONE, 1'b0, 16'h0000, 1'b0);
    act(OP_DATA_DONE, 1'b0, 16'hFFFF, 1'b0);
    act(OP_FAT_WORD, 1'b0, 16'h1234, 1'b0);

    // zero sectors per cluster: FAT requests only; top cluster, last word slot,
    // buffer smaller than file, end-of-chain marker
    quiesce();
    put_reg(REG_SPC, 32'h0000_0000);
    put_reg(REG_START_CLUS, 32'h0000_FFF7);
    put_reg(REG_FILE_LEN, 32'hFFFF_FFFF);
    put_reg(REG_BUF_CAP, 32'd600);
    cfg_valid <= 1'b0;
    act(OP_START, 1'b0, 16'h0000, 1'b0);
    act(OP_FAT_WORD, 1'b0, 16'd255, 1'b0);
    act(OP_FAT_WORD, 1'b0, 16'hFFF8, 1'b0);

    // read failures on a data sector and on a FAT sector
    quiesce();
    put_reg(REG_SPC, 32'd2);
    put_reg(REG_START_CLUS, 32'd3);
    put_reg(REG_FAT_START, 32'd0);
    put_reg(REG_DATA_START, 32'd0);
    put_reg(REG_FILE_LEN, 32'd5000);
    put_reg(REG_BUF_CAP, 32'd5000);
    cfg_valid <= 1'b0;
    act(OP_START, 1'b0, 16'h0000, 1'b0);
    act(OP_DATA_DONE, 1'b1, 16'h0000, 1'b0);
    act(OP_START, 1'b0, 16'h0000, 1'b0);
    act(OP_DATA_DONE, 1'b0, 16'h0000, 1'b0);
    act(OP_DATA_DONE, 1'b0, 16'h0000, 1'b0);
    act(OP_FAT_WORD, 1'b1, 16'd4, 1'b0);

    // end-of-chain start cluster; zero-byte buffer; write to an unused index
    quiesce();
    put_reg(REG_START_CLUS, 32'h0000_FFFF);
    cfg_valid <= 1'b0;
    act(OP_START, 1'b0, 16'h0000, 1'b0);
    quiesce();
    put_reg(REG_START_CLUS, 32'd5);
    put_reg(REG_BUF_CAP, 32'd0);
    put_reg(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    act(OP_START, 1'b0, 16'h0000, 1'b0);

    // --- random files ---
    while (items < ITEMS) begin
      quiesce();
      random_setup();
      act(OP_START, 1'($urandom), 16'($urandom), 1'b1);
      while (walk_at != PH_IDLE && items < ITEMS)
        act(fitting_op(walk_at), 1'($urandom_range(0, 99) < 3), chain_link(), 1'b1);
    end

    settle();
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("fat16_file_read_sequencer_core: match");
    else
      $display("fat16_file_read_sequencer_core: mismatch");
    $finish;
  end

endmodule
